FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge while rst_ni is high.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/wtre_pkg.sv
// ----------------------------------------------------------------------------
// wtre_pkg
// Shared types and codes of the window table request engine.
// ----------------------------------------------------------------------------
package wtre_pkg;

  // request opcodes
  localparam logic [7:0] OP_CREATE   = 8'd1;
  localparam logic [7:0] OP_DESTROY  = 8'd4;
  localparam logic [7:0] OP_MAP      = 8'd8;
  localparam logic [7:0] OP_GEOMETRY = 8'd14;

  // result status codes
  localparam logic [2:0] ST_REPLY       = 3'd0;
  localparam logic [2:0] ST_BAD_REQUEST = 3'd1;
  localparam logic [2:0] ST_BAD_VALUE   = 3'd2;
  localparam logic [2:0] ST_BAD_WINDOW  = 3'd3;
  localparam logic [2:0] ST_BAD_ID      = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_RESOURCE_BASE = 2'd0;
  localparam logic [1:0] CFG_RESOURCE_MASK = 2'd1;
  localparam logic [1:0] CFG_ROOT_WINDOW   = 2'd2;

  // byte lengths of well-formed requests
  localparam logic [15:0] PLEN_CREATE = 16'd32;
  localparam logic [15:0] PLEN_SHORT  = 16'd8;

  localparam logic [31:0] RESOURCE_BASE_RST = 32'h0020_0000;
  localparam logic [31:0] RESOURCE_MASK_RST = 32'h001F_FFFF;
  localparam logic [31:0] ROOT_WINDOW_RST   = 32'h0000_0001;

  typedef struct packed {
    logic [31:0]        id;
    logic               mapped;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [15:0]        border;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_ctl_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        seq;
    logic [31:0]        err_value;
    logic [7:0]         opcode;
    logic [31:0]        root;
    logic signed [15:0] geo_x;
    logic signed [15:0] geo_y;
    logic [15:0]        geo_width;
    logic [15:0]        geo_height;
    logic [15:0]        geo_border;
  } res_t;

endpackage

FILE: rtl/core/window_table_request_engine_top.sv
// ----------------------------------------------------------------------------
// window_table_request_engine_top
// Window table request engine: create, destroy, map and geometry requests
// against a table of NUM_WINDOWS window entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: drive the request fields and raise start_i; the beat is
//   taken at a clock edge with start_i high and busy_o low. busy_o stays high
//   until the request is finished.
//   Result beat: res_strobe_o is high for exactly one cycle with the result
//   fields; the receiver must take it then. Successful create, map and
//   destroy give no result beat.
//   Length and create-shape errors give the result from the check state
//   without a scan. All other requests scan the entry memory one entry
//   per cycle through its single read port, ending early on an id match.
//   A new request may be taken in the cycle its result is shown.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 resource base, 1 resource mask, 2 root window id); the user must
//   write only while idle, which the block itself does not enforce.
//   Reset: the table is empty, registers take their defaults, no strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module window_table_request_engine_top #(
  parameter int unsigned NUM_WINDOWS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         opcode_i,
  input  logic [15:0]        length_words_i,
  input  logic [15:0]        byte_len_i,
  input  logic [31:0]        sequence_req_i,
  input  logic [31:0]        window_id_i,
  input  logic [31:0]        parent_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  input  logic [15:0]        border_i,
  output logic               res_strobe_o,
  output logic [2:0]         status_o,
  output logic [31:0]        seq_echo_o,
  output logic [31:0]        err_value_o,
  output logic [7:0]         opcode_echo_o,
  output logic [31:0]        root_echo_o,
  output logic signed [15:0] geo_x_o,
  output logic signed [15:0] geo_y_o,
  output logic [15:0]        geo_width_o,
  output logic [15:0]        geo_height_o,
  output logic [15:0]        geo_border_o
);
  import wtre_pkg::*;

  localparam int unsigned IdxW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

  logic [31:0] resource_base_q;
  logic [31:0] resource_mask_q;
  logic [31:0] root_window_id_q;

  tbl_ctl_t               tbl_ctl;
  logic [IdxW-1:0]        tbl_rd_addr;
  logic [IdxW-1:0]        tbl_wr_addr;
  entry_t                 tbl_rd_data;
  entry_t                 tbl_wr_data;
  logic [NUM_WINDOWS-1:0] tbl_valid;
  res_t                   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resource_base_q  <= RESOURCE_BASE_RST;
      resource_mask_q  <= RESOURCE_MASK_RST;
      root_window_id_q <= ROOT_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESOURCE_BASE: resource_base_q  <= cfg_wdata_i;
        CFG_RESOURCE_MASK: resource_mask_q  <= cfg_wdata_i;
        CFG_ROOT_WINDOW:   root_window_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  wtre_ctrl #(
    .NumWindows(NUM_WINDOWS),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .length_words_i  (length_words_i),
    .byte_len_i      (byte_len_i),
    .sequence_req_i  (sequence_req_i),
    .window_id_i     (window_id_i),
    .parent_id_i     (parent_id_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .width_i         (width_i),
    .height_i        (height_i),
    .border_i        (border_i),
    .resource_base_i (resource_base_q),
    .resource_mask_i (resource_mask_q),
    .root_window_id_i(root_window_id_q),
    .tbl_ctl_o       (tbl_ctl),
    .rd_addr_o       (tbl_rd_addr),
    .rd_data_i       (tbl_rd_data),
    .wr_addr_o       (tbl_wr_addr),
    .wr_data_o       (tbl_wr_data),
    .valid_i         (tbl_valid),
    .res_strobe_o    (res_strobe_o),
    .res_o           (res)
  );

  wtre_table #(
    .NumWindows(NUM_WINDOWS),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tbl_ctl),
    .rd_addr_i(tbl_rd_addr),
    .rd_data_o(tbl_rd_data),
    .wr_addr_i(tbl_wr_addr),
    .wr_data_i(tbl_wr_data),
    .valid_o  (tbl_valid)
  );

  assign status_o      = res.status;
  assign seq_echo_o    = res.seq;
  assign err_value_o   = res.err_value;
  assign opcode_echo_o = res.opcode;
  assign root_echo_o   = res.root;
  assign geo_x_o       = res.geo_x;
  assign geo_y_o       = res.geo_y;
  assign geo_width_o   = res.geo_width;
  assign geo_height_o  = res.geo_height;
  assign geo_border_o  = res.geo_border;

  // results only come out once the sequencer is back to idle
  `ASSERT_RST(a_strobe_idle, res_strobe_o |-> !busy_o, "result beat while busy")
  `ASSERT_RST(a_strobe_single, res_strobe_o |=> !res_strobe_o, "result beat held two cycles")
  `ASSERT_RST(a_take_busy, (start_i && !busy_o) |=> busy_o, "request taken but not busy")
  // table contents change only at the end of a request
  `ASSERT_RST(a_valid_idle, !busy_o |=> $stable(tbl_valid), "valid bits changed while idle")

endmodule

FILE: rtl/core/wtre_table.sv
// ----------------------------------------------------------------------------
// wtre_table
// Window entry memory (one read, one write port, registered read) plus the
// per-entry valid bits in flops.
// ----------------------------------------------------------------------------
module wtre_table #(
  parameter int unsigned NumWindows = 16,
  parameter int unsigned IdxW       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wtre_pkg::tbl_ctl_t     ctl_i,
  input  logic [IdxW-1:0]        rd_addr_i,
  output wtre_pkg::entry_t       rd_data_o,
  input  logic [IdxW-1:0]        wr_addr_i,
  input  wtre_pkg::entry_t       wr_data_i,
  output logic [NumWindows-1:0]  valid_o
);
  import wtre_pkg::*;

  entry_t                mem_q [NumWindows];
  entry_t                rd_data_q;
  logic [NumWindows-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.set_valid) begin
      valid_q[wr_addr_i] <= 1'b1;
    end else if (ctl_i.clr_valid) begin
      valid_q[wr_addr_i] <= 1'b0;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

FILE: rtl/core/wtre_ctrl.sv
// ----------------------------------------------------------------------------
// wtre_ctrl
// Request sequencer: checks, table scan one entry per cycle, decision,
// write-back and result register.
// ----------------------------------------------------------------------------
module wtre_ctrl #(
  parameter int unsigned NumWindows = 16,
  parameter int unsigned IdxW       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [7:0]             opcode_i,
  input  logic [15:0]            length_words_i,
  input  logic [15:0]            byte_len_i,
  input  logic [31:0]            sequence_req_i,
  input  logic [31:0]            window_id_i,
  input  logic [31:0]            parent_id_i,
  input  logic signed [15:0]     pos_x_i,
  input  logic signed [15:0]     pos_y_i,
  input  logic [15:0]            width_i,
  input  logic [15:0]            height_i,
  input  logic [15:0]            border_i,
  input  logic [31:0]            resource_base_i,
  input  logic [31:0]            resource_mask_i,
  input  logic [31:0]            root_window_id_i,
  output wtre_pkg::tbl_ctl_t     tbl_ctl_o,
  output logic [IdxW-1:0]        rd_addr_o,
  input  wtre_pkg::entry_t       rd_data_i,
  output logic [IdxW-1:0]        wr_addr_o,
  output wtre_pkg::entry_t       wr_data_o,
  input  logic [NumWindows-1:0]  valid_i,
  output logic                   res_strobe_o,
  output wtre_pkg::res_t         res_o
);
  import wtre_pkg::*;

  localparam int unsigned CntW = $clog2(NumWindows + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            hit_q, hit_d;
  logic            free_q, free_d;
  logic            strobe_q;

  // request and scan payload
  logic [7:0]         op_q;
  logic [15:0]        words_q;
  logic [15:0]        plen_q;
  logic [31:0]        seq_q;
  logic [31:0]        id_q;
  logic [31:0]        parent_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic [15:0]        w_q;
  logic [15:0]        h_q;
  logic [15:0]        b_q;
  logic [IdxW-1:0]    pidx_q;
  logic [IdxW-1:0]    hit_idx_q;
  logic [IdxW-1:0]    free_idx_q;
  entry_t             hit_data_q;
  res_t               res_q;

  logic   accept;
  logic   is_create;
  logic   len_bad;
  logic   shape_bad;
  logic   range_bad;
  logic   size_zero;
  logic   short_req;
  logic   cmp_hit;
  logic   cmp_free;
  logic   rd_go;
  logic   emit;
  logic   emit_err;
  logic [2:0]  emit_status;
  logic [31:0] emit_value;
  res_t   emit_res;
  tbl_ctl_t ctl;
  entry_t   wr_data;

  assign accept    = (state_q == S_IDLE) && start_i;
  assign is_create = (op_q == OP_CREATE);
  assign len_bad   = (words_q == '0) || ({words_q, 2'b00} != {2'b00, plen_q});
  assign shape_bad = (plen_q != PLEN_CREATE) || (parent_q != root_window_id_i);
  assign range_bad = (id_q & ~resource_mask_i) != resource_base_i;
  assign size_zero = (w_q == '0) || (h_q == '0);
  assign short_req = (plen_q == PLEN_SHORT);

  // read data of the entry addressed last cycle
  assign cmp_hit  = pend_q && !hit_q && valid_i[pidx_q] && (rd_data_i.id == id_q);
  assign cmp_free = pend_q && !free_q && !valid_i[pidx_q];
  assign rd_go    = (state_q == S_SCAN) && (cnt_q < CntW'(NumWindows)) &&
                    !hit_q && !cmp_hit;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = rd_go;
    hit_d       = hit_q || cmp_hit;
    free_d      = free_q || cmp_free;
    emit        = 1'b0;
    emit_err    = 1'b1;
    emit_status = ST_BAD_REQUEST;
    emit_value  = id_q;
    ctl         = '0;
    ctl.rd_en   = rd_go;
    wr_data     = hit_data_q;
    wr_addr_o   = hit_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        if (len_bad) begin
          emit        = 1'b1;
          emit_status = ST_BAD_LENGTH;
          emit_value  = {16'd0, words_q};
          state_d     = S_IDLE;
        end else if (is_create && shape_bad) begin
          emit        = 1'b1;
          emit_status = ST_BAD_WINDOW;
          state_d     = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_go) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (!rd_go && !pend_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        if (is_create) begin
          wr_addr_o = free_idx_q;
          wr_data   = '{id: id_q, mapped: 1'b0, x: x_q, y: y_q,
                        width: w_q, height: h_q, border: b_q};
          if (range_bad || hit_q || !free_q) begin
            emit        = 1'b1;
            emit_status = ST_BAD_ID;
          end else if (size_zero) begin
            emit        = 1'b1;
            emit_status = ST_BAD_VALUE;
          end else begin
            ctl.wr_en     = 1'b1;
            ctl.set_valid = 1'b1;
          end
        end else if (!hit_q) begin
          emit        = 1'b1;
          emit_status = ST_BAD_WINDOW;
        end else if (short_req && (op_q == OP_MAP)) begin
          wr_data.mapped = 1'b1;
          ctl.wr_en      = 1'b1;
        end else if (short_req && (op_q == OP_DESTROY)) begin
          ctl.clr_valid = 1'b1;
        end else if (short_req && (op_q == OP_GEOMETRY)) begin
          emit        = 1'b1;
          emit_err    = 1'b0;
          emit_status = ST_REPLY;
        end else begin
          emit        = 1'b1;
          emit_status = ST_BAD_REQUEST;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit_res.status = emit_status;
    emit_res.seq    = seq_q;
    if (emit_err) begin
      emit_res.err_value  = emit_value;
      emit_res.opcode     = op_q;
      emit_res.root       = '0;
      emit_res.geo_x      = '0;
      emit_res.geo_y      = '0;
      emit_res.geo_width  = '0;
      emit_res.geo_height = '0;
      emit_res.geo_border = '0;
    end else begin
      emit_res.err_value  = '0;
      emit_res.opcode     = '0;
      emit_res.root       = root_window_id_i;
      emit_res.geo_x      = hit_data_q.x;
      emit_res.geo_y      = hit_data_q.y;
      emit_res.geo_width  = hit_data_q.width;
      emit_res.geo_height = hit_data_q.height;
      emit_res.geo_border = hit_data_q.border;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_i;
      words_q  <= length_words_i;
      plen_q   <= byte_len_i;
      seq_q    <= sequence_req_i;
      id_q     <= window_id_i;
      parent_q <= parent_id_i;
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      w_q      <= width_i;
      h_q      <= height_i;
      b_q      <= border_i;
    end
    if (rd_go) begin
      pidx_q <= cnt_q[IdxW-1:0];
    end
    if (cmp_hit) begin
      hit_idx_q  <= pidx_q;
      hit_data_q <= rd_data_i;
    end
    if (cmp_free) begin
      free_idx_q <= pidx_q;
    end
    if (emit) begin
      res_q <= emit_res;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign tbl_ctl_o    = ctl;
  assign rd_addr_o    = cnt_q[IdxW-1:0];
  assign wr_data_o    = wr_data;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule
